// ===== hw/rtl/pdar_pkg.sv =====
`timescale 1ns / 1ps

package pdar_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_LETTERS = 26;
	localparam int STACK_DEPTH = 64;
	localparam int MAX_POP     = 2;
	localparam int MAX_PUSH    = 2;

	localparam int TABLE_SIZE = NUM_STATES * NUM_LETTERS;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
	localparam int POP_LIM    = (MAX_POP > 2) ? 2 : MAX_POP;
	localparam int PUSH_LIM   = (MAX_PUSH > 2) ? 2 : MAX_PUSH;

	localparam int SYM_W = 8;
	localparam int ST_W  = 4;
	localparam int LTR_W = 5;
	localparam int LVL_W = 7;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [ST_W-1:0]  st_t;

	localparam sym_t SYM_MARKER  = 8'h24;
	localparam sym_t SYM_EPSILON = 8'h23;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_RULE   = 2'd1,
		CMD_LETTER = 2'd2,
		CMD_END    = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		REJ_NONE     = 2'd0,
		REJ_NO_RULE  = 2'd1,
		REJ_POP      = 2'd2,
		REJ_OVERFLOW = 2'd3
	} cause_e;

	// Net movement of the stack contents: DN moves symbols towards the top.
	typedef enum logic [2:0] {
		SH_DN2  = 3'd0,
		SH_DN1  = 3'd1,
		SH_HOLD = 3'd2,
		SH_UP1  = 3'd3,
		SH_UP2  = 3'd4
	} shift_e;

	typedef struct packed {
		logic [1:0]       command;
		st_t              from_state;
		logic [LTR_W-1:0] letter;
		logic [1:0]       pop_len;
		sym_t             pop_sym0;
		sym_t             pop_sym1;
		logic [1:0]       push_len;
		sym_t             push_sym0;
		sym_t             push_sym1;
		st_t              to_state;
	} item_t;

	typedef struct packed {
		logic             word_done;
		logic             accepted;
		logic [1:0]       reject_cause;
		st_t              current_state;
		logic [LVL_W-1:0] stack_level;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] pop_n;
		sym_t       pop_s0;
		sym_t       pop_s1;
		logic [1:0] push_n;
		sym_t       push_s0;
		sym_t       push_s1;
		st_t        next;
	} rule_t;

	typedef struct packed {
		logic   en;
		shift_e sh;
	} cell_ctrl_t;

	typedef struct packed {
		cell_ctrl_t cc;
		logic       ld0;
		logic       ld1;
		sym_t       sym0;
		sym_t       sym1;
	} stk_ctrl_t;

	function automatic logic [1:0] clamp_len(logic [1:0] v, int lim);
		logic [1:0] r;
		r = (int'(v) > lim) ? 2'(lim) : v;
		return r;
	endfunction

endpackage

// ===== hw/rtl/pdar_ram.sv =====
`timescale 1ns / 1ps

module pdar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/pdar_cell.sv =====
`timescale 1ns / 1ps

module pdar_cell import pdar_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       ld,
	input  sym_t       ld_sym,
	input  sym_t       up2,
	input  sym_t       up1,
	input  sym_t       dn1,
	input  sym_t       dn2,
	output sym_t       sym
);

	sym_t sym_q;

	// Take a pushed symbol, or the neighbour's symbol that the move brings here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= SYM_MARKER;
		end else if (ctrl.en) begin
			if (ld) begin
				sym_q <= ld_sym;
			end else begin
				unique case (ctrl.sh)
					SH_DN2:  sym_q <= dn2;
					SH_DN1:  sym_q <= dn1;
					SH_HOLD: sym_q <= sym_q;
					SH_UP1:  sym_q <= up1;
					SH_UP2:  sym_q <= up2;
					default: sym_q <= sym_q;
				endcase
			end
		end
	end

	assign sym = sym_q;

endmodule

// ===== hw/rtl/pdar_stack.sv =====
`timescale 1ns / 1ps

module pdar_stack import pdar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_ctrl_t ctrl,
	output sym_t      top0,
	output sym_t      top1
);

	// Chain with two blank slots at each end; cell j sits at slot j+2.
	sym_t ext [STACK_DEPTH + 4];

	assign ext[0]               = '0;
	assign ext[1]               = '0;
	assign ext[STACK_DEPTH + 2] = '0;
	assign ext[STACK_DEPTH + 3] = '0;

	for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
		logic ld;
		sym_t ld_sym;

		if (j == 0) begin : g_top
			assign ld     = ctrl.ld0;
			assign ld_sym = ctrl.sym0;
		end else if (j == 1) begin : g_next
			assign ld     = ctrl.ld1;
			assign ld_sym = ctrl.sym1;
		end else begin : g_deep
			assign ld     = 1'b0;
			assign ld_sym = '0;
		end

		pdar_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl.cc),
			.ld     (ld),
			.ld_sym (ld_sym),
			.up2    (ext[j]),
			.up1    (ext[j + 1]),
			.dn1    (ext[j + 3]),
			.dn2    (ext[j + 4]),
			.sym    (ext[j + 2])
		);
	end

	assign top0 = ext[2];
	assign top1 = ext[3];

endmodule

// ===== hw/rtl/pushdown_automaton_recognizer_unit.sv =====
`timescale 1ns / 1ps

// Deterministic pushdown recogniser driven by a rule table.
// Input channel item/item_valid/item_stall carries one command per beat:
// start word, write rule, feed letter or end of word. Output channel
// result/result_valid/result_stall returns exactly one result beat per
// input beat, in order: word_done and accepted on an end-of-word beat, and
// after every beat the sticky reject cause, the state and the stack level.
// A result passes through the issue stage and the output register.
// Start, rule and end beats are taken one per cycle while the output is
// not stalled; a letter beat holds the input until it leaves the issue
// stage, so the next letter's rule-table address sees the state that the
// current letter produces; the table RAM read is registered.
// The stack is a row of shifting cells with the top in cell 0, so the two
// symbols a rule may pop are always at hand.
// Reset: the block clears the rule table, one entry a cycle, in one pass over
// states times letters with item_stall high; state, stack level and reject
// cause come up as after a start word.
// A stalled result beat holds in the output register; the input keeps
// taking beats until the one in flight has nowhere to go.
module pushdown_automaton_recognizer_unit import pdar_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// Table clearing pass after reset
	logic              clr_act_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	// Issue stage: holds the beat while its rule is read
	logic       valid_s1;
	cmd_e       cmd_s1;
	logic       in_rng_s1;

	// Automaton state
	st_t          state_q;
	cause_e       rej_q;
	logic [CNT_W-1:0] cnt_q;

	// Output register
	logic    result_valid_q;
	result_t result_q;

	logic item_acc;
	logic adv;

	always_comb begin
		adv        = valid_s1 && (!result_valid_q || !result_stall);
		// Hold the input while clearing, while the issue stage is blocked, and
		// while a letter sits in the issue stage so the next read sees its new state.
		item_stall = clr_act_q || (valid_s1 && (!adv || cmd_s1 == CMD_LETTER));
		item_acc   = item_valid && !item_stall;
	end

	// ---------------------------------------------------------------
	// Rule table
	// ---------------------------------------------------------------
	st_t               rd_state;
	logic              ltr_rng;
	logic              wr_rng;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	rule_t             new_rule;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	rule_t             ram_wdata;
	logic [$bits(rule_t)-1:0] ram_rdata;
	rule_t             ent;

	always_comb begin
		// A start in the issue stage puts the state to zero this edge.
		rd_state = (valid_s1 && cmd_s1 == CMD_START) ? '0 : state_q;
		ltr_rng  = int'(item.letter) < NUM_LETTERS;
		wr_rng   = ltr_rng && (int'(item.from_state) < NUM_STATES);
		rd_addr  = ltr_rng ? ADDR_W'(int'(rd_state) * NUM_LETTERS + int'(item.letter)) : '0;
		wr_addr  = ADDR_W'(int'(item.from_state) * NUM_LETTERS + int'(item.letter));

		new_rule.valid   = 1'b1;
		new_rule.pop_n   = clamp_len(item.pop_len, POP_LIM);
		new_rule.pop_s0  = item.pop_sym0;
		new_rule.pop_s1  = item.pop_sym1;
		new_rule.push_n  = clamp_len(item.push_len, PUSH_LIM);
		new_rule.push_s0 = item.push_sym0;
		new_rule.push_s1 = item.push_sym1;
		new_rule.next    = item.to_state;

		ram_we    = clr_act_q || (item_acc && item.command == CMD_RULE && wr_rng);
		ram_waddr = clr_act_q ? clr_cnt_q : wr_addr;
		ram_wdata = clr_act_q ? '0 : new_rule;
	end

	pdar_ram #(
		.WIDTH ($bits(rule_t)),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (item_acc),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign ent = rule_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_act_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(TABLE_SIZE - 1)) begin
				clr_act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			cmd_s1    <= CMD_START;
			in_rng_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1  <= 1'b1;
			cmd_s1    <= cmd_e'(item.command);
			in_rng_s1 <= ltr_rng;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Symbol stack
	// ---------------------------------------------------------------
	stk_ctrl_t stk_ctrl;
	sym_t      top0;
	sym_t      top1;

	pdar_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stk_ctrl),
		.top0   (top0),
		.top1   (top1)
	);

	// ---------------------------------------------------------------
	// Execute: check the rule against the top of stack, then move
	// ---------------------------------------------------------------
	logic             pop_fail;
	logic             psh0;
	logic             psh1;
	logic [1:0]       npush;
	logic [2:0]       net;
	logic [CNT_W:0]   new_cnt;
	logic             ovf;
	logic             st_rng;
	st_t              nxt_state;
	cause_e           nxt_rej;
	logic [CNT_W-1:0] nxt_cnt;
	logic             done;
	logic             acc;
	logic             apply;
	shift_e           sh;

	always_comb begin
		// Popping below the bottom counts as a mismatch.
		pop_fail = ((ent.pop_n >= 2'd1) && (cnt_q < CNT_W'(1) || top0 != ent.pop_s0)) ||
		           ((ent.pop_n >= 2'd2) && (cnt_q < CNT_W'(2) || top1 != ent.pop_s1));
		// Drop epsilon pushes.
		psh0  = (ent.push_n >= 2'd1) && (ent.push_s0 != SYM_EPSILON);
		psh1  = (ent.push_n >= 2'd2) && (ent.push_s1 != SYM_EPSILON);
		npush = {1'b0, psh0} + {1'b0, psh1};
		net   = {1'b0, npush} - {1'b0, ent.pop_n};

		new_cnt = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(npush) - (CNT_W+1)'(ent.pop_n);
		ovf     = new_cnt > (CNT_W+1)'(STACK_DEPTH);
		st_rng  = int'(state_q) < NUM_STATES;

		unique case (net)
			3'b010:  sh = SH_UP2;
			3'b001:  sh = SH_UP1;
			3'b000:  sh = SH_HOLD;
			3'b111:  sh = SH_DN1;
			3'b110:  sh = SH_DN2;
			default: sh = SH_HOLD;
		endcase

		nxt_state = state_q;
		nxt_rej   = rej_q;
		nxt_cnt   = cnt_q;
		done      = 1'b0;
		acc       = 1'b0;
		apply     = 1'b0;

		stk_ctrl.cc.en = 1'b0;
		stk_ctrl.cc.sh = SH_HOLD;
		stk_ctrl.ld0   = 1'b0;
		stk_ctrl.ld1   = 1'b0;
		stk_ctrl.sym0  = SYM_MARKER;
		stk_ctrl.sym1  = ent.push_s1;

		unique case (cmd_s1)
			CMD_START: begin
				nxt_state      = '0;
				nxt_rej        = REJ_NONE;
				nxt_cnt        = CNT_W'(1);
				stk_ctrl.cc.en = adv;
				stk_ctrl.ld0   = 1'b1;
			end
			CMD_RULE: begin
			end
			CMD_LETTER: begin
				// A rejected word ignores further letters.
				if (rej_q == REJ_NONE) begin
					priority if (!in_rng_s1 || !st_rng || !ent.valid) begin
						nxt_rej = REJ_NO_RULE;
					end else if (pop_fail) begin
						nxt_rej = REJ_POP;
					end else if (ovf) begin
						nxt_rej = REJ_OVERFLOW;
					end else begin
						apply = 1'b1;
					end
				end
			end
			CMD_END: begin
				done = 1'b1;
				acc  = (rej_q == REJ_NONE) && (cnt_q == CNT_W'(1)) && (top0 == SYM_MARKER);
			end
		endcase

		if (apply) begin
			nxt_state      = ent.next;
			nxt_cnt        = new_cnt[CNT_W-1:0];
			stk_ctrl.cc.en = adv;
			stk_ctrl.cc.sh = sh;
			stk_ctrl.ld0   = npush != 2'd0;
			stk_ctrl.ld1   = npush == 2'd2;
			stk_ctrl.sym0  = psh0 ? ent.push_s0 : ent.push_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rej_q   <= REJ_NONE;
			cnt_q   <= CNT_W'(1);
		end else if (adv) begin
			state_q <= nxt_state;
			rej_q   <= nxt_rej;
			cnt_q   <= nxt_cnt;
		end
	end

	// Output register: load on advance, drop once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.word_done     <= done;
			result_q.accepted      <= acc;
			result_q.reject_cause  <= nxt_rej;
			result_q.current_state <= nxt_state;
			result_q.stack_level   <= LVL_W'(nxt_cnt);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack level above depth");

	a_letter_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.command == CMD_LETTER) |=> !item_acc)
		else $error("beat taken right behind a letter");

	a_reject_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == CMD_LETTER && rej_q != REJ_NONE) |=>
		($stable(state_q) && $stable(cnt_q)))
		else $error("rejected word moved state or stack");

	a_reject_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rej_q != REJ_NONE && !(adv && cmd_s1 == CMD_START)) |=> rej_q == $past(rej_q))
		else $error("reject cause changed without a start");

endmodule

// ===== sim/pushdown_automaton_recognizer_unit_test.sv =====
`timescale 1ns / 1ps

// Checks the pushdown recogniser against a behavioural predictor of its own.
module pushdown_automaton_recognizer_unit_test;
	import pdar_pkg::*;

	// Run shape
	localparam int ITEM_TARGET = 950;   // beats queued in all, at the least
	localparam int TAIL_BEATS  = 120;   // last beats go without any idling
	localparam int HOLD_AT     = 300;   // result beat after which the receiver holds off
	localparam int HOLD_CYCLES = 80;    // long enough to back the block up to its input
	localparam int IDLE_LIMIT  = 5000;  // covers the table clearing pass after reset
	localparam int SETTLE      = 10;

	localparam int POP_CAP  = (MAX_POP < 2) ? MAX_POP : 2;
	localparam int PUSH_CAP = (MAX_PUSH < 2) ? MAX_PUSH : 2;

	// Two copies of the predictor state: one steers generation, one follows
	// the beats the block actually takes.
	localparam int PLAN = 0;
	localparam int LIVE = 1;

	localparam sym_t SYM_A = 8'h41;
	localparam sym_t SYM_B = 8'h42;
	localparam sym_t SYM_Z = 8'h5A;

	typedef struct packed {
		logic  drain;   // hold this beat back until every result is in
		item_t beat;
	} pending_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	pushdown_automaton_recognizer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hold reset at the start, then release it for good.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor state
	// ------------------------------------------------------------------
	rule_t       rules      [2][TABLE_SIZE];
	sym_t        sym_stack  [2][STACK_DEPTH];
	int unsigned stack_fill [2];
	st_t         fsm_state  [2];
	cause_e      cause_held [2];

	pending_t pending_beats[$];
	result_t  due_results[$];

	int queued      = 0;
	int failures    = 0;
	int send_gap    = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	int beats_out   = 0;
	int idle_cycles = 0;

	function automatic void begin_word(input int m);
		sym_stack[m][0] = SYM_MARKER;
		stack_fill[m]   = 1;
		fsm_state[m]    = '0;
		cause_held[m]   = REJ_NONE;
	endfunction

	// Apply one beat to model m and return the result beat it should produce.
	function automatic result_t recognise_beat(input int m, input item_t b);
		result_t     r;
		rule_t       ru;
		int unsigned lvl;
		int unsigned npush;
		int unsigned i;
		sym_t        order [2];
		logic        bad;
		r        = '0;
		order[0] = '0;
		order[1] = '0;
		unique case (cmd_e'(b.command))
		CMD_START: begin
			begin_word(m);
		end
		CMD_RULE: begin
			// out-of-range writes leave the table alone
			if (int'(b.from_state) < NUM_STATES && int'(b.letter) < NUM_LETTERS) begin
				ru.valid   = 1'b1;
				ru.pop_n   = (int'(b.pop_len) > POP_CAP) ? 2'(POP_CAP) : b.pop_len;
				ru.pop_s0  = b.pop_sym0;
				ru.pop_s1  = b.pop_sym1;
				ru.push_n  = (int'(b.push_len) > PUSH_CAP) ? 2'(PUSH_CAP) : b.push_len;
				ru.push_s0 = b.push_sym0;
				ru.push_s1 = b.push_sym1;
				ru.next    = b.to_state;
				rules[m][int'(b.from_state) * NUM_LETTERS + int'(b.letter)] = ru;
			end
		end
		CMD_LETTER: begin
			// once rejected, letters are dropped until the next start
			if (cause_held[m] == REJ_NONE) begin
				if (int'(b.letter) >= NUM_LETTERS) begin
					cause_held[m] = REJ_NO_RULE;
				end else begin
					ru  = rules[m][int'(fsm_state[m]) * NUM_LETTERS + int'(b.letter)];
					lvl = stack_fill[m];
					bad = 1'b0;
					// popping past the bottom counts as a mismatch
					if (ru.pop_n >= 2'd1 && (lvl < 1 || sym_stack[m][lvl - 1] != ru.pop_s0))
						bad = 1'b1;
					if (ru.pop_n >= 2'd2 && (lvl < 2 || sym_stack[m][lvl - 2] != ru.pop_s1))
						bad = 1'b1;
					if (!ru.valid) begin
						cause_held[m] = REJ_NO_RULE;
					end else if (bad) begin
						cause_held[m] = REJ_POP;
					end else begin
						lvl   = lvl - ru.pop_n;
						npush = 0;
						// deeper symbol goes in first; epsilon pushes nothing
						if (ru.push_n >= 2'd2 && ru.push_s1 != SYM_EPSILON) begin
							order[npush] = ru.push_s1;
							npush        = npush + 1;
						end
						if (ru.push_n >= 2'd1 && ru.push_s0 != SYM_EPSILON) begin
							order[npush] = ru.push_s0;
							npush        = npush + 1;
						end
						if (lvl + npush > STACK_DEPTH) begin
							cause_held[m] = REJ_OVERFLOW;
						end else begin
							for (i = 0; i < npush; i++)
								sym_stack[m][lvl + i] = order[i];
							stack_fill[m] = lvl + npush;
							fsm_state[m]  = ru.next;
						end
					end
				end
			end
		end
		CMD_END: begin
			r.word_done = 1'b1;
			r.accepted  = (cause_held[m] == REJ_NONE && stack_fill[m] == 1 &&
			               sym_stack[m][0] == SYM_MARKER);
		end
		endcase
		r.reject_cause  = cause_held[m];
		r.current_state = fsm_state[m];
		r.stack_level   = LVL_W'(stack_fill[m]);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void queue_beat(input item_t b);
		pending_t p;
		p.drain = (queued == ITEM_TARGET / 2);
		p.beat  = b;
		pending_beats = {pending_beats, p};
		void'(recognise_beat(PLAN, b));
		queued = queued + 1;
	endfunction

	function automatic item_t noise_beat();
		logic [63:0] raw;
		item_t       b;
		raw = {$urandom, $urandom};
		b   = raw[$bits(item_t)-1:0];
		return b;
	endfunction

	function automatic item_t cmd_beat(input cmd_e c, input int l);
		item_t b;
		b         = noise_beat();
		b.command = c;
		b.letter  = LTR_W'(l);
		return b;
	endfunction

	function automatic item_t rule_beat(input int f, input int l, input int pl,
	                                    input sym_t p0, input sym_t p1, input int ql,
	                                    input sym_t q0, input sym_t q1, input int t);
		item_t b;
		b            = cmd_beat(CMD_RULE, l);
		b.from_state = ST_W'(f);
		b.pop_len    = 2'(pl);
		b.pop_sym0   = p0;
		b.pop_sym1   = p1;
		b.push_len   = 2'(ql);
		b.push_sym0  = q0;
		b.push_sym1  = q1;
		b.to_state   = ST_W'(t);
		return b;
	endfunction

	// Small symbol alphabet so that pops match often.
	function automatic sym_t pick_sym();
		unique case ($urandom_range(0, 5))
		0:       return SYM_MARKER;
		1:       return SYM_EPSILON;
		2, 3:    return SYM_A;
		4:       return SYM_B;
		default: return sym_t'($urandom);
		endcase
	endfunction

	// Rules mostly over a few states and letters; now and then anything at all.
	function automatic item_t random_rule();
		item_t b;
		b         = noise_beat();
		b.command = CMD_RULE;
		if ($urandom_range(0, 7) != 0) begin
			b.from_state = ST_W'($urandom_range(0, 3));
			b.letter     = LTR_W'($urandom_range(0, 5));
			b.pop_sym0   = pick_sym();
			b.pop_sym1   = pick_sym();
			b.push_sym0  = pick_sym();
			b.push_sym1  = pick_sym();
			b.to_state   = ST_W'($urandom_range(0, 3));
		end
		return b;
	endfunction

	// Prefer letters whose rule exists and whose first pop matches the top.
	function automatic int steer_letter();
		int          fits [$];
		rule_t       ru;
		int unsigned lvl;
		int          l;
		lvl = stack_fill[PLAN];
		for (l = 0; l < NUM_LETTERS; l++) begin
			ru = rules[PLAN][int'(fsm_state[PLAN]) * NUM_LETTERS + l];
			if (ru.valid && (ru.pop_n == 2'd0 ||
			    (lvl > 0 && sym_stack[PLAN][lvl - 1] == ru.pop_s0)))
				fits = {fits, l};
		end
		if (fits.size() == 0 || $urandom_range(0, 7) == 0)
			return $urandom_range(0, 31);
		return fits[$urandom_range(0, fits.size() - 1)];
	endfunction

	function automatic void queue_word();
		int len;
		queue_beat(cmd_beat(CMD_START, $urandom_range(0, 31)));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(0, 16);
		repeat (len) begin
			if ($urandom_range(0, 19) == 0)
				queue_beat(random_rule());
			else
				queue_beat(cmd_beat(CMD_LETTER, steer_letter()));
		end
		// the odd word is left open and the next start cuts it off
		if ($urandom_range(0, 15) != 0)
			queue_beat(cmd_beat(CMD_END, $urandom_range(0, 31)));
	endfunction

	// Climb the stack with a self-loop until it overflows; single pushes
	// pass through a full stack of exactly STACK_DEPTH on the way.
	function automatic void queue_climb();
		logic two;
		int   len;
		two = 1'($urandom_range(0, 1));
		queue_beat(rule_beat(0, 7, 0, pick_sym(), pick_sym(), 2, SYM_A,
		                     two ? SYM_B : SYM_EPSILON, 0));
		queue_beat(cmd_beat(CMD_START, 7));
		len = two ? 34 : 66;
		repeat (len) queue_beat(cmd_beat(CMD_LETTER, 7));
		queue_beat(cmd_beat(CMD_END, 7));
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
	                                      input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures = failures + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int m;
		int i;
		int choice;
		for (m = 0; m < 2; m++) begin
			for (i = 0; i < TABLE_SIZE; i++) rules[m][i] = '0;
			for (i = 0; i < STACK_DEPTH; i++) sym_stack[m][i] = '0;
			begin_word(m);
		end

		// empty word, then out-of-range letter and sticky rejection
		queue_beat(cmd_beat(CMD_START, 0));
		queue_beat(cmd_beat(CMD_END, 0));
		queue_beat(cmd_beat(CMD_LETTER, 31));
		queue_beat(cmd_beat(CMD_LETTER, 0));
		queue_beat(cmd_beat(CMD_END, 0));
		// rule write off the end of the table: dropped
		queue_beat(rule_beat(15, 31, 3, 8'hFF, 8'hFF, 3, 8'hFF, 8'hFF, 15));
		// a^n b^n, plus rules for the corner cases
		queue_beat(rule_beat(0, 0, 0, 8'h00, 8'h00, 1, SYM_A, SYM_B, 0));
		queue_beat(rule_beat(0, 1, 1, SYM_A, 8'hFF, 0, 8'h00, 8'h00, 1));
		queue_beat(rule_beat(1, 1, 1, SYM_A, 8'h00, 0, 8'hFF, 8'hFF, 1));
		queue_beat(rule_beat(1, 2, 3, SYM_MARKER, 8'hFF, 0, 8'h00, 8'h00, 2));
		queue_beat(rule_beat(1, 3, 1, SYM_MARKER, 8'h00, 3, SYM_Z, SYM_EPSILON, 15));
		queue_beat(rule_beat(15, 25, 0, 8'h00, 8'hFF, 2, 8'hFF, 8'h00, 15));
		// aabb is accepted
		queue_beat(cmd_beat(CMD_START, 0));
		queue_beat(cmd_beat(CMD_LETTER, 0));
		queue_beat(cmd_beat(CMD_LETTER, 0));
		queue_beat(cmd_beat(CMD_LETTER, 1));
		queue_beat(cmd_beat(CMD_LETTER, 1));
		queue_beat(cmd_beat(CMD_END, 0));
		// double pop with only the marker left: pops below the bottom
		queue_beat(cmd_beat(CMD_LETTER, 2));
		queue_beat(cmd_beat(CMD_END, 0));
		// pop of A against the marker
		queue_beat(cmd_beat(CMD_START, 0));
		queue_beat(cmd_beat(CMD_LETTER, 1));
		// marker swapped for Z: one symbol left but not accepted; then the
		// extreme rule pushes two
		queue_beat(cmd_beat(CMD_START, 0));
		queue_beat(cmd_beat(CMD_LETTER, 0));
		queue_beat(cmd_beat(CMD_LETTER, 1));
		queue_beat(cmd_beat(CMD_LETTER, 3));
		queue_beat(cmd_beat(CMD_END, 0));
		queue_beat(cmd_beat(CMD_LETTER, 25));
		queue_beat(cmd_beat(CMD_END, 0));

		// random part: mostly rule batches followed by steered words
		while (queued < ITEM_TARGET) begin
			choice = $urandom_range(0, 23);
			if (choice == 0) begin
				repeat ($urandom_range(1, 4)) queue_beat(noise_beat());
			end else if (choice == 1) begin
				queue_climb();
			end else begin
				repeat ($urandom_range(0, 5)) queue_beat(random_rule());
				queue_word();
			end
		end

		// sample away from the clock edge so the driver has settled
		while (pending_beats.size() != 0 || item_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: offer pending beats, predict each one as it is taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic     offer;
		item_t    next_beat;
		pending_t p;
		offer     = item_valid;
		next_beat = item;
		if (!arst_n) begin
			offer = 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				due_results = {due_results, recognise_beat(LIVE, item)};
				offer = 1'b0;
				// idle in bursts, but not over the tail
				if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 9);
			end
			// hold the payload while stalled; only refill once the beat has gone
			if (!offer) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
				end else if (pending_beats.size() != 0 &&
				             !(pending_beats[0].drain && due_results.size() != 0)) begin
					p         = pending_beats.pop_front();
					offer     = 1'b1;
					next_beat = p.beat;
				end
			end
		end
		item_valid <= offer;
		item       <= next_beat;
	end

	// ------------------------------------------------------------------
	// Monitor: check each result beat against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic    hold;
		result_t want;
		hold = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result beat with nothing due, expected none, got %h",
					         $time, result);
					failures = failures + 1;
				end else begin
					want = due_results.pop_front();
					compare_field("word_done", 8'(want.word_done), 8'(result.word_done));
					compare_field("accepted", 8'(want.accepted), 8'(result.accepted));
					compare_field("reject_cause", 8'(want.reject_cause),
					              8'(result.reject_cause));
					compare_field("current_state", 8'(want.current_state),
					              8'(result.current_state));
					compare_field("stack_level", 8'(want.stack_level),
					              8'(result.stack_level));
				end
				beats_out = beats_out + 1;
				// one long hold-off so the block backs up and stalls its input
				if (beats_out == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold      = 1'b1;
				hold_left = hold_left - 1;
			end else if (stall_left != 0) begin
				hold       = 1'b1;
				stall_left = stall_left - 1;
			end else if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 6) == 0) begin
				hold       = 1'b1;
				stall_left = $urandom_range(0, 8);
			end
		end
		result_stall <= hold;
	end

	// Watchdog: give up after a long run of cycles with no beat on either side.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
